// ===== rtl/led_blink_pattern_controller_assert.svh =====
// Assertion macros for the LED blink and pattern controller.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef LED_BLINK_PATTERN_CONTROLLER_ASSERT_SVH
`define LED_BLINK_PATTERN_CONTROLLER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LBPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LBPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lbpc_pkg.sv =====
// Package for the LED blink and pattern controller.
// Holds command and mode codes, register reset values and field widths.
`timescale 1ns / 1ps

package lbpc_pkg;

  localparam int CmdW   = 3;
  localparam int CountW = 8;
  localparam int TimeW  = 16;
  localparam int ModeW  = 2;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [CmdW-1:0] CMD_TICK    = 3'd0;
  localparam logic [CmdW-1:0] CMD_ON      = 3'd1;
  localparam logic [CmdW-1:0] CMD_OFF     = 3'd2;
  localparam logic [CmdW-1:0] CMD_TOGGLE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_BLINK   = 3'd4;
  localparam logic [CmdW-1:0] CMD_PATTERN = 3'd5;
  localparam logic [CmdW-1:0] CMD_FLASH   = 3'd6;
  localparam logic [CmdW-1:0] CMD_PAUSE   = 3'd7;

  localparam logic [ModeW-1:0] MODE_OFF     = 2'd0;
  localparam logic [ModeW-1:0] MODE_ON      = 2'd1;
  localparam logic [ModeW-1:0] MODE_BLINK   = 2'd2;
  localparam logic [ModeW-1:0] MODE_PATTERN = 2'd3;

  localparam logic [1:0] REG_ON_TIME     = 2'd0;
  localparam logic [1:0] REG_OFF_TIME    = 2'd1;
  localparam logic [1:0] REG_PAUSE_TIME  = 2'd2;
  localparam logic [1:0] REG_ENDING_TIME = 2'd3;

  localparam logic [TimeW-1:0] ON_TIME_RST     = 16'd250;
  localparam logic [TimeW-1:0] OFF_TIME_RST    = 16'd250;
  localparam logic [TimeW-1:0] PAUSE_TIME_RST  = 16'd500;
  localparam logic [TimeW-1:0] ENDING_TIME_RST = 16'd1000;
  localparam logic [TimeW-1:0] TIME_MAX        = 16'hFFFF;

  typedef struct packed {
    logic             led_level;
    logic [ModeW-1:0] mode;
  } result_t;

endpackage

// ===== rtl/lbpc_if.sv =====
// Valid/ready channel interfaces for the command and result streams.
// Depends on lbpc_pkg for field widths.
`timescale 1ns / 1ps

interface lbpc_in_if;
  logic                           valid;
  logic                           ready;
  logic [lbpc_pkg::CmdW-1:0]      command;
  logic [lbpc_pkg::CountW-1:0]    first_count;
  logic [lbpc_pkg::CountW-1:0]    second_count;
  logic                           repeat_req;
  logic [lbpc_pkg::TimeW-1:0]     hold_ms;

  modport source (output valid, command, first_count, second_count, repeat_req,
                  hold_ms, input ready);
  modport sink (input valid, command, first_count, second_count, repeat_req,
                hold_ms, output ready);
endinterface

interface lbpc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        led_level;
  logic [lbpc_pkg::ModeW-1:0]  mode;

  modport source (output valid, led_level, mode, input ready);
  modport sink (input valid, led_level, mode, output ready);
endinterface

// ===== rtl/led_blink_pattern_controller.sv =====
// LED blink and pattern controller: one command or millisecond tick accepted per cycle
// while the skid entry is free, one result (LED level and mode) per command. A two-entry
// output register decouples the result channel, so a new command is taken every cycle
// while the second entry is free. Each command updates the mode state in the cycle it
// is transferred; its result is registered into the output entry, or into the skid
// entry when that is held. One command per cycle is sustained while results are taken.
// Depends on lbpc_pkg, lbpc_if and led_blink_pattern_controller_assert.svh.
`timescale 1ns / 1ps
`include "led_blink_pattern_controller_assert.svh"

module led_blink_pattern_controller (
  input  logic                          clk,
  input  logic                          rst_n,
  lbpc_in_if.sink                       in_ch,
  lbpc_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [lbpc_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [lbpc_pkg::DataW-1:0]    cfg_pwdata,
  output logic [lbpc_pkg::DataW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  logic [lbpc_pkg::TimeW-1:0] on_time_r, off_time_r, pause_time_r, ending_time_r;

  logic [lbpc_pkg::ModeW-1:0]  mode_r, mode_nxt;
  logic                        led_r, led_nxt;
  logic [lbpc_pkg::TimeW-1:0]  since_r, since_nxt;
  logic [lbpc_pkg::CountW-1:0] first_rem_r, first_rem_nxt;
  logic [lbpc_pkg::CountW-1:0] second_rem_r, second_rem_nxt;
  logic [lbpc_pkg::CountW-1:0] first_start_r, first_start_nxt;
  logic [lbpc_pkg::CountW-1:0] second_start_r, second_start_nxt;
  logic                        repeat_r, repeat_nxt;
  logic                        ov_active_r, ov_active_nxt;
  logic                        ov_level_r, ov_level_nxt;
  logic [lbpc_pkg::TimeW-1:0]  ov_elapsed_r, ov_elapsed_nxt;
  logic [lbpc_pkg::TimeW-1:0]  ov_len_r, ov_len_nxt;

  lbpc_pkg::result_t result_nxt, out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              in_fire, out_fire, cfg_write;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign out_fire  = out_valid_r && out_ch.ready;
  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  assign in_ch.ready    = !skid_valid_r;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.led_level = out_r.led_level;
  assign out_ch.mode    = out_r.mode;
  assign cfg_pready     = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      lbpc_pkg::REG_ON_TIME:     cfg_prdata = {16'd0, on_time_r};
      lbpc_pkg::REG_OFF_TIME:    cfg_prdata = {16'd0, off_time_r};
      lbpc_pkg::REG_PAUSE_TIME:  cfg_prdata = {16'd0, pause_time_r};
      lbpc_pkg::REG_ENDING_TIME: cfg_prdata = {16'd0, ending_time_r};
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_time_r     <= lbpc_pkg::ON_TIME_RST;
      off_time_r    <= lbpc_pkg::OFF_TIME_RST;
      pause_time_r  <= lbpc_pkg::PAUSE_TIME_RST;
      ending_time_r <= lbpc_pkg::ENDING_TIME_RST;
    end else if (cfg_write) begin
      case (cfg_paddr[3:2])
        lbpc_pkg::REG_ON_TIME:     on_time_r     <= cfg_pwdata[15:0];
        lbpc_pkg::REG_OFF_TIME:    off_time_r    <= cfg_pwdata[15:0];
        lbpc_pkg::REG_PAUSE_TIME:  pause_time_r  <= cfg_pwdata[15:0];
        lbpc_pkg::REG_ENDING_TIME: ending_time_r <= cfg_pwdata[15:0];
        default:                   on_time_r     <= on_time_r;
      endcase
    end
  end

  always_comb begin
    mode_nxt         = mode_r;
    led_nxt          = led_r;
    since_nxt        = since_r;
    first_rem_nxt    = first_rem_r;
    second_rem_nxt   = second_rem_r;
    first_start_nxt  = first_start_r;
    second_start_nxt = second_start_r;
    repeat_nxt       = repeat_r;
    ov_active_nxt    = ov_active_r;
    ov_level_nxt     = ov_level_r;
    ov_elapsed_nxt   = ov_elapsed_r;
    ov_len_nxt       = ov_len_r;

    case (in_ch.command)
      lbpc_pkg::CMD_TICK: begin
        if (since_r != lbpc_pkg::TIME_MAX) begin
          since_nxt = since_r + 16'd1;
        end
        if (ov_active_r) begin
          if (ov_elapsed_r >= ov_len_r) begin
            ov_active_nxt = 1'b0;
          end else begin
            ov_elapsed_nxt = ov_elapsed_r + 16'd1;
          end
        end
        if (ov_active_nxt) begin
          if (mode_r == lbpc_pkg::MODE_BLINK || mode_r == lbpc_pkg::MODE_PATTERN) begin
            led_nxt = ov_level_r;
          end
        end else if (mode_r == lbpc_pkg::MODE_BLINK) begin
          if (led_r && since_nxt >= on_time_r) begin
            led_nxt   = 1'b0;
            since_nxt = '0;
          end else if (!led_r && since_nxt >= off_time_r) begin
            led_nxt   = 1'b1;
            since_nxt = '0;
          end
        end else if (mode_r == lbpc_pkg::MODE_PATTERN) begin
          if (first_rem_r != '0) begin
            if (led_r && since_nxt >= on_time_r) begin
              led_nxt       = 1'b0;
              since_nxt     = '0;
              first_rem_nxt = first_rem_r - 8'd1;
            end else if (!led_r && since_nxt >= off_time_r) begin
              led_nxt   = 1'b1;
              since_nxt = '0;
            end
          end else if (second_rem_r != '0) begin
            if (since_nxt >= pause_time_r) begin
              led_nxt        = 1'b1;
              since_nxt      = '0;
              first_rem_nxt  = second_rem_r;
              second_rem_nxt = '0;
            end
          end else if (repeat_r) begin
            if (since_nxt >= ending_time_r) begin
              led_nxt        = 1'b1;
              since_nxt      = '0;
              first_rem_nxt  = first_start_r;
              second_rem_nxt = second_start_r;
            end
          end else begin
            mode_nxt = lbpc_pkg::MODE_OFF;
            led_nxt  = 1'b0;
          end
        end
      end
      lbpc_pkg::CMD_ON: begin
        mode_nxt = lbpc_pkg::MODE_ON;
        led_nxt  = 1'b1;
      end
      lbpc_pkg::CMD_OFF: begin
        mode_nxt = lbpc_pkg::MODE_OFF;
        led_nxt  = 1'b0;
      end
      lbpc_pkg::CMD_TOGGLE: begin
        if (mode_r == lbpc_pkg::MODE_OFF) begin
          mode_nxt = lbpc_pkg::MODE_ON;
          led_nxt  = 1'b1;
        end else begin
          mode_nxt = lbpc_pkg::MODE_OFF;
          led_nxt  = 1'b0;
        end
      end
      lbpc_pkg::CMD_BLINK: begin
        if (mode_r != lbpc_pkg::MODE_BLINK) begin
          mode_nxt  = lbpc_pkg::MODE_BLINK;
          led_nxt   = 1'b1;
          since_nxt = '0;
        end
      end
      lbpc_pkg::CMD_PATTERN: begin
        repeat_nxt = in_ch.repeat_req;
        if (mode_r != lbpc_pkg::MODE_PATTERN || first_start_r != in_ch.first_count ||
            second_start_r != in_ch.second_count) begin
          mode_nxt         = lbpc_pkg::MODE_PATTERN;
          first_start_nxt  = in_ch.first_count;
          second_start_nxt = in_ch.second_count;
          first_rem_nxt    = in_ch.first_count;
          second_rem_nxt   = in_ch.second_count;
          led_nxt          = 1'b1;
          since_nxt        = '0;
        end
      end
      lbpc_pkg::CMD_FLASH: begin
        ov_active_nxt  = 1'b1;
        ov_level_nxt   = 1'b1;
        ov_elapsed_nxt = '0;
        ov_len_nxt     = in_ch.hold_ms;
      end
      lbpc_pkg::CMD_PAUSE: begin
        ov_active_nxt  = 1'b1;
        ov_level_nxt   = 1'b0;
        ov_elapsed_nxt = '0;
        ov_len_nxt     = in_ch.hold_ms;
      end
      default: begin
        ov_active_nxt = ov_active_r;
      end
    endcase

    result_nxt.led_level = ov_active_nxt ? ov_level_nxt : led_nxt;
    result_nxt.mode      = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= lbpc_pkg::MODE_OFF;
      led_r          <= 1'b0;
      since_r        <= '0;
      first_rem_r    <= '0;
      second_rem_r   <= '0;
      first_start_r  <= '0;
      second_start_r <= '0;
      repeat_r       <= 1'b0;
      ov_active_r    <= 1'b0;
      ov_level_r     <= 1'b0;
      ov_elapsed_r   <= '0;
      ov_len_r       <= '0;
    end else if (in_fire) begin
      mode_r         <= mode_nxt;
      led_r          <= led_nxt;
      since_r        <= since_nxt;
      first_rem_r    <= first_rem_nxt;
      second_rem_r   <= second_rem_nxt;
      first_start_r  <= first_start_nxt;
      second_start_r <= second_start_nxt;
      repeat_r       <= repeat_nxt;
      ov_active_r    <= ov_active_nxt;
      ov_level_r     <= ov_level_nxt;
      ov_elapsed_r   <= ov_elapsed_nxt;
      ov_len_r       <= ov_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_r <= result_nxt;
      end else begin
        skid_r <= result_nxt;
      end
    end
  end

  `LBPC_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r,
                    "Skid entry holds a result while the output entry is empty.")
  `LBPC_ASSERT_SAME(a_overlay_bound, ov_active_r, ov_elapsed_r <= ov_len_r,
                    "Overlay elapsed time ran past its length.")
  `LBPC_ASSERT_SAME(a_permanent_level,
                    mode_r == lbpc_pkg::MODE_OFF || mode_r == lbpc_pkg::MODE_ON,
                    led_r == (mode_r == lbpc_pkg::MODE_ON),
                    "Permanent mode does not match its LED level.")
  `LBPC_ASSERT_NEXT(a_pattern_enters,
                    in_fire && in_ch.command == lbpc_pkg::CMD_PATTERN,
                    mode_r == lbpc_pkg::MODE_PATTERN,
                    "Pattern command did not enter pattern mode.")

endmodule

// ===== tb/led_blink_pattern_controller_tb.sv =====
// Self-checking testbench for the LED blink and pattern controller.
// A scoreboard class predicts the LED level and mode for every command transfer.
// Depends on lbpc_pkg, lbpc_if and the led_blink_pattern_controller RTL.
`timescale 1ns / 1ps

import lbpc_pkg::*;

typedef struct packed {
  logic [CmdW-1:0]   command;
  logic [CountW-1:0] first_count;
  logic [CountW-1:0] second_count;
  logic              repeat_req;
  logic [TimeW-1:0]  hold_ms;
} led_cmd_t;

class led_scoreboard;
  logic [TimeW-1:0]  on_time, off_time, pause_time, ending_time;
  logic [ModeW-1:0]  cur_mode;
  logic              led_on;
  logic [TimeW-1:0]  since_toggle;
  logic [CountW-1:0] first_left, second_left, first_init, second_init;
  logic              repeat_on;
  logic              ovl_active, ovl_level;
  logic [TimeW-1:0]  ovl_elapsed, ovl_length;
  result_t           expected_leds[$];
  int unsigned       errors;

  function new();
    on_time      = ON_TIME_RST;
    off_time     = OFF_TIME_RST;
    pause_time   = PAUSE_TIME_RST;
    ending_time  = ENDING_TIME_RST;
    cur_mode     = MODE_OFF;
    led_on       = 1'b0;
    since_toggle = '0;
    first_left   = '0;
    second_left  = '0;
    first_init   = '0;
    second_init  = '0;
    repeat_on    = 1'b0;
    ovl_active   = 1'b0;
    ovl_level    = 1'b0;
    ovl_elapsed  = '0;
    ovl_length   = '0;
    errors       = 0;
  endfunction

  function void set_timing(logic [1:0] idx, logic [TimeW-1:0] value);
    case (idx)
      REG_ON_TIME:     on_time = value;
      REG_OFF_TIME:    off_time = value;
      REG_PAUSE_TIME:  pause_time = value;
      REG_ENDING_TIME: ending_time = value;
      default: ;
    endcase
  endfunction

  function void set_steady(logic lit);
    cur_mode = lit ? MODE_ON : MODE_OFF;
    led_on   = lit;
  endfunction

  function void restart_phase(logic lit);
    led_on       = lit;
    since_toggle = '0;
  endfunction

  function void step_pattern();
    if (first_left != 0) begin
      if (led_on && since_toggle >= on_time) begin
        restart_phase(1'b0);
        first_left = first_left - 1'b1;
      end else if (!led_on && since_toggle >= off_time) begin
        restart_phase(1'b1);
      end
    end else if (second_left != 0) begin
      if (since_toggle >= pause_time) begin
        restart_phase(1'b1);
        first_left  = second_left;
        second_left = '0;
      end
    end else if (repeat_on) begin
      if (since_toggle >= ending_time) begin
        restart_phase(1'b1);
        first_left  = first_init;
        second_left = second_init;
      end
    end else begin
      set_steady(1'b0);
    end
  endfunction

  function void advance_one_ms();
    if (since_toggle != TIME_MAX) since_toggle = since_toggle + 1'b1;
    if (ovl_active) begin
      if (ovl_elapsed >= ovl_length) ovl_active = 1'b0;
      else ovl_elapsed = ovl_elapsed + 1'b1;
    end
    if (ovl_active) begin
      if (cur_mode == MODE_BLINK || cur_mode == MODE_PATTERN) led_on = ovl_level;
    end else if (cur_mode == MODE_BLINK) begin
      if (led_on && since_toggle >= on_time) restart_phase(1'b0);
      else if (!led_on && since_toggle >= off_time) restart_phase(1'b1);
    end else if (cur_mode == MODE_PATTERN) begin
      step_pattern();
    end
  endfunction

  function void start_overlay(logic level, logic [TimeW-1:0] length);
    ovl_active  = 1'b1;
    ovl_level   = level;
    ovl_elapsed = '0;
    ovl_length  = length;
  endfunction

  function void note_command(led_cmd_t c);
    result_t r;
    case (c.command)
      CMD_TICK:   advance_one_ms();
      CMD_ON:     set_steady(1'b1);
      CMD_OFF:    set_steady(1'b0);
      CMD_TOGGLE: set_steady(cur_mode == MODE_OFF);
      CMD_BLINK: begin
        if (cur_mode != MODE_BLINK) begin
          cur_mode = MODE_BLINK;
          restart_phase(1'b1);
        end
      end
      CMD_PATTERN: begin
        repeat_on = c.repeat_req;
        if (cur_mode != MODE_PATTERN || first_init != c.first_count ||
            second_init != c.second_count) begin
          cur_mode    = MODE_PATTERN;
          first_init  = c.first_count;
          second_init = c.second_count;
          first_left  = c.first_count;
          second_left = c.second_count;
          restart_phase(1'b1);
        end
      end
      CMD_FLASH: start_overlay(1'b1, c.hold_ms);
      default:   start_overlay(1'b0, c.hold_ms);
    endcase
    r.led_level = ovl_active ? ovl_level : led_on;
    r.mode      = cur_mode;
    expected_leds.push_back(r);
  endfunction

  function void check_result(logic led_level, logic [ModeW-1:0] mode);
    result_t exp_r;
    if (expected_leds.size() == 0) begin
      $error("result with no expectation waiting: led_level %0d mode %0d", led_level, mode);
      errors++;
      return;
    end
    exp_r = expected_leds.pop_front();
    if (led_level !== exp_r.led_level) begin
      $error("led_level: expected %0d, actual %0d", exp_r.led_level, led_level);
      errors++;
    end
    if (mode !== exp_r.mode) begin
      $error("mode: expected %0d, actual %0d", exp_r.mode, mode);
      errors++;
    end
  endfunction

  function int pending();
    return expected_leds.size();
  endfunction
endclass

module led_blink_pattern_controller_tb;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 250;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [AddrW-1:0] cfg_paddr;
  logic [DataW-1:0] cfg_pwdata;
  logic [DataW-1:0] cfg_prdata;
  logic cfg_pready;

  lbpc_in_if  in_ch();
  lbpc_out_if out_ch();

  led_scoreboard sb = new();

  logic              sender_calm = 1'b0;
  logic              receiver_calm = 1'b0;
  logic [CountW-1:0] last_first = '0;
  logic [CountW-1:0] last_second = '0;
  int unsigned       cycle_cnt = 0;

  led_blink_pattern_controller dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic led_cmd_t make_cmd(logic [CmdW-1:0] command, logic [CountW-1:0] n1,
                                        logic [CountW-1:0] n2, logic rep,
                                        logic [TimeW-1:0] dur);
    led_cmd_t c;
    c.command      = command;
    c.first_count  = n1;
    c.second_count = n2;
    c.repeat_req   = rep;
    c.hold_ms      = dur;
    return c;
  endfunction

  function automatic led_cmd_t random_cmd();
    led_cmd_t c;
    int unsigned pick;
    c.first_count  = CountW'($urandom());
    c.second_count = CountW'($urandom());
    c.repeat_req   = 1'($urandom());
    c.hold_ms      = TimeW'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 55) c.command = CMD_TICK;
    else if (pick < 60) c.command = CMD_ON;
    else if (pick < 64) c.command = CMD_OFF;
    else if (pick < 68) c.command = CMD_TOGGLE;
    else if (pick < 74) c.command = CMD_BLINK;
    else if (pick < 86) c.command = CMD_PATTERN;
    else if (pick < 93) c.command = CMD_FLASH;
    else c.command = CMD_PAUSE;
    if (c.command == CMD_PATTERN) begin
      if ($urandom_range(0, 2) == 0) begin
        c.first_count  = last_first;
        c.second_count = last_second;
      end else if ($urandom_range(0, 7) != 0) begin
        c.first_count  = CountW'($urandom_range(0, 3));
        c.second_count = ($urandom_range(0, 3) == 0) ? '0 : CountW'($urandom_range(0, 3));
      end
      last_first  = c.first_count;
      last_second = c.second_count;
    end else if ((c.command == CMD_FLASH || c.command == CMD_PAUSE) &&
                 $urandom_range(0, 9) != 0) begin
      c.hold_ms = TimeW'($urandom_range(0, 8));
    end
    return c;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [TimeW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= AddrW'({idx, 2'b00});
    cfg_pwdata  <= DataW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_timing(idx, value);
  endtask

  task automatic program_timing(logic [TimeW-1:0] on_t, logic [TimeW-1:0] off_t,
                                logic [TimeW-1:0] pause_t, logic [TimeW-1:0] end_t);
    cfg_write(REG_ON_TIME, on_t);
    cfg_write(REG_OFF_TIME, off_t);
    cfg_write(REG_PAUSE_TIME, pause_t);
    cfg_write(REG_ENDING_TIME, end_t);
  endtask

  task automatic send_cmd(led_cmd_t c);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= c.command;
    in_ch.first_count  <= c.first_count;
    in_ch.second_count <= c.second_count;
    in_ch.repeat_req   <= c.repeat_req;
    in_ch.hold_ms      <= c.hold_ms;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(c);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned stall;
    int unsigned n;
    n = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (n % 32 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
      stall = receiver_calm ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      sb.check_result(out_ch.led_level, out_ch.mode);
      n++;
    end
  end

  initial begin
    led_cmd_t directed[$];
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_TICK;
    in_ch.first_count  <= '0;
    in_ch.second_count <= '0;
    in_ch.repeat_req   <= 1'b0;
    in_ch.hold_ms      <= '0;
    cfg_psel           <= 1'b0;
    cfg_penable        <= 1'b0;
    cfg_pwrite         <= 1'b0;
    cfg_paddr          <= '0;
    cfg_pwdata         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    program_timing(16'd2, 16'd1, 16'd3, 16'd2);
    directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_ON, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_TOGGLE, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_TOGGLE, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_OFF, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_BLINK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_BLINK, 8'd0, 8'd0, 1'b0, 16'd0));
    repeat (3) directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_PATTERN, 8'd255, 8'd255, 1'b1, 16'd0));
    directed.push_back(make_cmd(CMD_PATTERN, 8'd255, 8'd255, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_PATTERN, 8'd0, 8'd2, 1'b1, 16'd0));
    repeat (4) directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_FLASH, 8'd0, 8'd0, 1'b0, 16'hFFFF));
    directed.push_back(make_cmd(CMD_PAUSE, 8'd0, 8'd0, 1'b0, 16'd0));
    repeat (2) directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_PATTERN, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_FLASH, 8'd0, 8'd0, 1'b0, 16'd0));
    directed.push_back(make_cmd(CMD_TICK, 8'd0, 8'd0, 1'b0, 16'd0));
    foreach (directed[i]) send_cmd(directed[i]);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (2) @(posedge clk);
      case (p)
        0: program_timing('0, '0, '0, '0);
        1: program_timing(TIME_MAX, TIME_MAX, TIME_MAX, TIME_MAX);
        default: program_timing(TimeW'($urandom_range(0, 6)), TimeW'($urandom_range(0, 6)),
                                TimeW'($urandom_range(0, 10)), TimeW'($urandom_range(0, 10)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 32 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 149) == 0) drain_results();
        send_cmd(random_cmd());
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/lbpc_pkg.sv
rtl/lbpc_if.sv
rtl/led_blink_pattern_controller.sv
tb/led_blink_pattern_controller_tb.sv
